@@ design/k3c_pkg.sv @@
// ----------------------------------------------------------------------------
// k3c_pkg: shared types and constants of the 3x3 RGBA convolution
// Command and status bundles between controller and datapath, register
// indexes, reset values and fixed datapath widths.
// ----------------------------------------------------------------------------
package k3c_pkg;

	localparam int DEF_MAX_WIDTH = 2048;

	localparam int PIX_W   = 32;
	localparam int COEF_W  = 16;
	localparam int ROW_W   = 48;
	localparam int GAIN_W  = 18;
	localparam int BIAS_W  = 11;
	localparam int LW_W    = 12;
	localparam int W_W     = 13;
	localparam int OFF_W   = 15;
	localparam int ACC_W   = 28;
	localparam int PROD_W  = 47;
	localparam int T_W     = 48;
	localparam int FRAC_W  = 26;
	localparam int CNT_W   = 32;

	localparam int CFG_DW  = 64;
	localparam int CFG_AW  = 6;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_KTOP  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KMID  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KBOT  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GAIN  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BIAS  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LINEW = 3'd5;

	localparam logic [ROW_W-1:0]  RST_KTOP  = 48'h0;
	localparam logic [ROW_W-1:0]  RST_KMID  = 48'h0000_1000_0000;
	localparam logic [ROW_W-1:0]  RST_KBOT  = 48'h0;
	localparam logic [GAIN_W-1:0] RST_GAIN  = 18'd16384;
	localparam logic [BIAS_W-1:0] RST_BIAS  = 11'd0;
	localparam logic [LW_W-1:0]   RST_LINEW = 12'd2048;

	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam logic [7:0] CHAN_MAX = 8'hFF;

	typedef enum logic [1:0] {
		SRC_FIRST = 2'd0,
		SRC_NEW   = 2'd1,
		SRC_MEM   = 2'd2
	} src_t;

	typedef struct packed {
		logic       latch;
		logic       decide;
		logic       tap_issue;
		logic       tap_acc;
		logic [1:0] tap_row;
		logic [1:0] tap_col;
		logic       wr_en;
		logic       mul_en;
		logic       fin_en;
		logic [1:0] ch;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic emit;
		logic push_write;
		logic out_free;
	} status_t;

endpackage

@@ design/k3c_ram.sv @@
// ----------------------------------------------------------------------------
// k3c_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module k3c_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4098
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/k3c_ctrl.sv @@
// ----------------------------------------------------------------------------
// k3c_ctrl: sequencer of the 3x3 RGBA convolution
// Accepts a request, lets the datapath decide, steps the nine taps, writes
// the delay line, scales four channels and hands the result to the output.
// ----------------------------------------------------------------------------
module k3c_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  k3c_pkg::status_t st,
	output k3c_pkg::cmd_t    cmd
);

	import k3c_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_TAP    = 6'b000100,
		S_WR     = 6'b001000,
		S_SCALE  = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] k_q, k_d;
	logic [1:0] row_q, row_d, col_q, col_d;
	logic       emit_q, wr_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		row_d   = row_q;
		col_d   = col_q;
		cmd     = '0;
		cmd.tap_row = row_q;
		cmd.tap_col = col_q;
		cmd.ch      = k_q[1:0];
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				k_d   = '0;
				row_d = '0;
				col_d = '0;
				if (st.emit) begin
					state_d = S_TAP;
				end else if (st.push_write) begin
					state_d = S_WR;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_TAP: begin
				cmd.tap_issue = (k_q < 4'd9);
				cmd.tap_acc   = (k_q != 4'd0);
				if (k_q == 4'd9) begin
					k_d     = '0;
					state_d = wr_q ? S_WR : S_SCALE;
				end else begin
					k_d = k_q + 4'd1;
					if (col_q == 2'd2) begin
						col_d = '0;
						row_d = row_q + 2'd1;
					end else begin
						col_d = col_q + 2'd1;
					end
				end
			end
			S_WR: begin
				cmd.wr_en = 1'b1;
				k_d       = '0;
				state_d   = emit_q ? S_SCALE : S_IDLE;
			end
			S_SCALE: begin
				cmd.mul_en = (k_q < 4'd4);
				cmd.fin_en = (k_q != 4'd0);
				if (k_q == 4'd4) begin
					k_d     = '0;
					state_d = S_OUT;
				end else begin
					k_d = k_q + 4'd1;
				end
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			row_q   <= '0;
			col_q   <= '0;
			emit_q  <= 1'b0;
			wr_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			row_q   <= row_d;
			col_q   <= col_d;
			if (state_q == S_DECIDE) begin
				emit_q <= st.emit;
				wr_q   <= st.push_write;
			end
		end
	end

endmodule

@@ design/k3c_dp.sv @@
// ----------------------------------------------------------------------------
// k3c_dp: datapath of the 3x3 RGBA convolution
// Frame counters, delay line, tap addressing, multiply-accumulate, gain and
// bias scaling with clamp, and the output register.
// ----------------------------------------------------------------------------
module k3c_dp #(
	parameter int MAX_WIDTH = k3c_pkg::DEF_MAX_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  k3c_pkg::cmd_t                 cmd,
	output k3c_pkg::status_t              st,
	input  logic                          command,
	input  logic [k3c_pkg::PIX_W-1:0]     pixel_in,
	input  logic                          frame_end,
	input  logic [k3c_pkg::ROW_W-1:0]     krow_top,
	input  logic [k3c_pkg::ROW_W-1:0]     krow_mid,
	input  logic [k3c_pkg::ROW_W-1:0]     krow_bot,
	input  logic [k3c_pkg::GAIN_W-1:0]    gain,
	input  logic [k3c_pkg::BIAS_W-1:0]    bias,
	input  logic [k3c_pkg::W_W-1:0]       width_eff,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [k3c_pkg::PIX_W-1:0]     pixel_out,
	output logic                          frame_last
);

	import k3c_pkg::*;

	localparam int DEPTH = 2 * MAX_WIDTH + 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = (AW > OFF_W ? AW : OFF_W) + 2;
	localparam int IW    = CNT_W + 3;

	// latched request
	logic             cmd_q;
	logic [PIX_W-1:0] pix_q;
	logic             end_q;

	// frame state
	logic [PIX_W-1:0] first_q;
	logic [CNT_W-1:0] recv_q, emit_q;
	logic             closed_q;
	logic [AW-1:0]    wr_ptr_q, ep_ptr_q;

	// per-item context
	logic [CNT_W-1:0] p_q;
	logic [CNT_W:0]   cnt_q;
	logic             cclosed_q, have_new_q, last_q;
	logic [PIX_W-1:0] newv_q;
	logic [AW-1:0]    base_q, laddr_q, waddr_q;

	// decision
	logic             push, wr_ok, rdy, emit, lst, clr, cl;
	logic [CNT_W:0]   cnt, e33;
	logic [CNT_W-1:0] recv_n, e_n;
	logic             closed_n;
	logic [AW-1:0]    wr_inc, ep_inc, wr_dec;

	assign push  = (cmd_q == CMD_PUSH);
	assign cnt   = push ? ({1'b0, recv_q} + 33'd1) : {1'b0, recv_q};
	assign cl    = push ? end_q : closed_q;
	assign e33   = {1'b0, emit_q};
	assign wr_ok = push && !closed_q;
	assign rdy   = (e33 < cnt) &&
		(cl || ({1'b0, cnt} > ({1'b0, e33} + 34'(width_eff) + 34'd1)));
	assign emit  = !(push && closed_q) && rdy;
	assign lst   = emit && cl && ((e33 + 33'd1) == cnt);

	assign recv_n   = wr_ok ? recv_q + 32'd1 : recv_q;
	assign closed_n = wr_ok ? end_q : closed_q;
	assign e_n      = emit ? emit_q + 32'd1 : emit_q;
	assign clr      = emit && closed_n && (e_n == recv_n);

	assign wr_inc = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
	assign ep_inc = (ep_ptr_q == AW'(DEPTH - 1)) ? '0 : ep_ptr_q + AW'(1);
	assign wr_dec = (wr_ptr_q == '0) ? AW'(DEPTH - 1) : wr_ptr_q - AW'(1);

	assign st.emit       = emit;
	assign st.push_write = wr_ok;
	assign st.out_free   = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q <= command;
			pix_q <= pixel_in;
			end_q <= frame_end;
		end
		if (cmd.decide) begin
			p_q        <= emit_q;
			cnt_q      <= cnt;
			cclosed_q  <= cl;
			have_new_q <= push;
			newv_q     <= pix_q;
			last_q     <= lst;
			base_q     <= ep_ptr_q;
			laddr_q    <= push ? wr_ptr_q : wr_dec;
			waddr_q    <= wr_ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			recv_q   <= '0;
			emit_q   <= '0;
			closed_q <= 1'b0;
			wr_ptr_q <= '0;
			ep_ptr_q <= '0;
		end else if (cmd.decide) begin
			if (wr_ok && (recv_q == '0)) begin
				first_q <= pix_q;
			end
			if (clr) begin
				recv_q   <= '0;
				emit_q   <= '0;
				closed_q <= 1'b0;
				wr_ptr_q <= '0;
				ep_ptr_q <= '0;
			end else begin
				recv_q   <= recv_n;
				emit_q   <= e_n;
				closed_q <= closed_n;
				wr_ptr_q <= wr_ok ? wr_inc : wr_ptr_q;
				ep_ptr_q <= emit ? ep_inc : ep_ptr_q;
			end
		end
	end

	// tap addressing
	logic signed [OFF_W-1:0]  roff, coff, off;
	logic signed [IW-1:0]     idx, cnt_m1, idx_e;
	logic                     hi;
	logic signed [SW-1:0]     s_raw, s_fix;
	logic [AW-1:0]            raddr;
	logic [ROW_W-1:0]         krow;
	logic [COEF_W-1:0]        coef;
	src_t                     src;
	logic [PIX_W-1:0]         rdata;

	always_comb begin
		case (cmd.tap_row)
			2'd0:    roff = -$signed(OFF_W'(width_eff));
			2'd2:    roff = $signed(OFF_W'(width_eff));
			default: roff = '0;
		endcase
		case (cmd.tap_col)
			2'd0:    coff = -OFF_W'(1);
			2'd2:    coff = OFF_W'(1);
			default: coff = '0;
		endcase
		case (cmd.tap_row)
			2'd0:    krow = krow_top;
			2'd2:    krow = krow_bot;
			default: krow = krow_mid;
		endcase
		case (cmd.tap_col)
			2'd0:    coef = krow[15:0];
			2'd2:    coef = krow[47:32];
			default: coef = krow[31:16];
		endcase
	end

	assign off    = roff + coff;
	assign idx    = $signed({3'b000, p_q}) + IW'(off);
	assign cnt_m1 = $signed({2'b00, cnt_q}) - IW'(1);
	assign hi     = cclosed_q && (idx > cnt_m1);
	assign idx_e  = hi ? cnt_m1 : idx;

	always_comb begin
		if (idx_e <= 0) begin
			src = SRC_FIRST;
		end else if (have_new_q && (idx_e == cnt_m1)) begin
			src = SRC_NEW;
		end else begin
			src = SRC_MEM;
		end
	end

	assign s_raw = $signed(SW'({1'b0, base_q})) + SW'(off);
	always_comb begin
		if (s_raw < 0) begin
			s_fix = s_raw + SW'(DEPTH);
		end else if (s_raw >= SW'(DEPTH)) begin
			s_fix = s_raw - SW'(DEPTH);
		end else begin
			s_fix = s_raw;
		end
	end
	assign raddr = hi ? laddr_q : s_fix[AW-1:0];

	k3c_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_line (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(waddr_q),
		.wdata(newv_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	// multiply-accumulate
	src_t                     src_s1;
	logic signed [COEF_W-1:0] coef_s1;
	logic                     center_s1;
	logic signed [ACC_W-1:0]  acc_r_q, acc_g_q, acc_b_q;
	logic [7:0]               own_q;
	logic [PIX_W-1:0]         tpix;

	always_comb begin
		case (src_s1)
			SRC_FIRST: tpix = first_q;
			SRC_NEW:   tpix = newv_q;
			default:   tpix = rdata;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.tap_issue) begin
			src_s1    <= src;
			coef_s1   <= $signed(coef);
			center_s1 <= (cmd.tap_row == 2'd1) && (cmd.tap_col == 2'd1);
		end
		if (cmd.decide) begin
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
		end else if (cmd.tap_acc) begin
			acc_r_q <= acc_r_q + ACC_W'($signed({1'b0, tpix[31:24]}) * coef_s1);
			acc_g_q <= acc_g_q + ACC_W'($signed({1'b0, tpix[23:16]}) * coef_s1);
			acc_b_q <= acc_b_q + ACC_W'($signed({1'b0, tpix[15:8]}) * coef_s1);
			if (center_s1) begin
				own_q <= tpix[7:0];
			end
		end
	end

	// scaling: alpha enters as a Q.12 value so all four share one path
	logic signed [ACC_W-1:0]  op;
	logic signed [PROD_W-1:0] prod_s1;
	logic [1:0]               ch_s1;
	logic signed [T_W-1:0]    tval;
	logic [7:0]               chan;
	logic [7:0]               res_q [4];

	always_comb begin
		case (cmd.ch)
			2'd0:    op = acc_r_q;
			2'd1:    op = acc_g_q;
			2'd2:    op = acc_b_q;
			default: op = $signed({8'b0, own_q, 12'b0});
		endcase
	end

	assign tval = T_W'(prod_s1) + (T_W'($signed(bias)) <<< FRAC_W);

	always_comb begin
		if (tval < 0) begin
			chan = '0;
		end else if (tval[T_W-1:FRAC_W] > (T_W - FRAC_W)'(CHAN_MAX)) begin
			chan = CHAN_MAX;
		end else begin
			chan = tval[FRAC_W+7:FRAC_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= PROD_W'(op * $signed({1'b0, gain}));
			ch_s1   <= cmd.ch;
		end
		if (cmd.fin_en) begin
			res_q[ch_s1] <= chan;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pixel_out  <= {res_q[0], res_q[1], res_q[2], res_q[3]};
			frame_last <= last_q;
		end
	end

endmodule

@@ design/kernel3x3_rgba_convolution_top.sv @@
// ----------------------------------------------------------------------------
// kernel3x3_rgba_convolution_top: 3x3 RGBA convolution with gain and bias
// Raster pixel stream in, filtered pixel stream out, APB register file.
//
//   channel   signals                                   accepted when
//   input     in_valid in_ready command pixel_in        in_valid & in_ready
//             frame_end
//   output    out_valid out_ready pixel_out frame_last  out_valid & out_ready
//   config    psel penable pwrite paddr pwdata prdata   psel & penable & pwrite
//             pready
//
// A request that emits a pixel loads it after nine taps read one at a time
// through the single read port of the delay line, a push into an open frame
// writing the delay line, and four channel scalings that share one multiplier.
// The next request can be accepted in the cycle after the load. A request
// that emits nothing only writes the delay line on a push into an open frame.
// No clearing pass after reset. in_ready is high only between requests; a
// result held in the output register blocks only the load of the next result.
// ----------------------------------------------------------------------------
module kernel3x3_rgba_convolution_top #(
	parameter int MAX_WIDTH = k3c_pkg::DEF_MAX_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [k3c_pkg::PIX_W-1:0]     pixel_in,
	input  logic                          frame_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [k3c_pkg::PIX_W-1:0]     pixel_out,
	output logic                          frame_last,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [k3c_pkg::CFG_AW-1:0]    paddr,
	input  logic [k3c_pkg::CFG_DW-1:0]    pwdata,
	output logic [k3c_pkg::CFG_DW-1:0]    prdata,
	output logic                          pready
);

	import k3c_pkg::*;

	logic [ROW_W-1:0]     ktop_q, kmid_q, kbot_q;
	logic [GAIN_W-1:0]    gain_q;
	logic [BIAS_W-1:0]    bias_q;
	logic [LW_W-1:0]      linew_q;
	logic [W_W-1:0]       width_eff;
	logic [REG_IDX_W-1:0] ridx;
	logic                 wr;
	cmd_t                 cmd;
	status_t              st;

	assign pready = 1'b1;
	assign ridx   = paddr[CFG_AW-1:CFG_AW-REG_IDX_W];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ktop_q  <= RST_KTOP;
			kmid_q  <= RST_KMID;
			kbot_q  <= RST_KBOT;
			gain_q  <= RST_GAIN;
			bias_q  <= RST_BIAS;
			linew_q <= RST_LINEW;
		end else if (wr) begin
			unique case (ridx)
				REG_KTOP:  ktop_q  <= pwdata[ROW_W-1:0];
				REG_KMID:  kmid_q  <= pwdata[ROW_W-1:0];
				REG_KBOT:  kbot_q  <= pwdata[ROW_W-1:0];
				REG_GAIN:  gain_q  <= pwdata[GAIN_W-1:0];
				REG_BIAS:  bias_q  <= pwdata[BIAS_W-1:0];
				REG_LINEW: linew_q <= pwdata[LW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_KTOP:  prdata = CFG_DW'(ktop_q);
			REG_KMID:  prdata = CFG_DW'(kmid_q);
			REG_KBOT:  prdata = CFG_DW'(kbot_q);
			REG_GAIN:  prdata = CFG_DW'(gain_q);
			REG_BIAS:  prdata = CFG_DW'(bias_q);
			REG_LINEW: prdata = CFG_DW'(linew_q);
			default:   prdata = '0;
		endcase
	end

	// clamp line width into 4..MAX_WIDTH
	always_comb begin
		if (linew_q < LW_W'(4)) begin
			width_eff = W_W'(4);
		end else if ({2'b00, linew_q} > 14'(MAX_WIDTH)) begin
			width_eff = W_W'(MAX_WIDTH);
		end else begin
			width_eff = W_W'(linew_q);
		end
	end

	k3c_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.st      (st),
		.cmd     (cmd)
	);

	k3c_dp #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.command   (command),
		.pixel_in  (pixel_in),
		.frame_end (frame_end),
		.krow_top  (ktop_q),
		.krow_mid  (kmid_q),
		.krow_bot  (kbot_q),
		.gain      (gain_q),
		.bias      (bias_q),
		.width_eff (width_eff),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.frame_last(frame_last)
	);

endmodule
